@@ src/mcra_pkg.sv @@
// Shared types and constants for the minima-controlled noise estimator.
// Holds the request structs, the per-bin state word and the fixed-point weights.
// No dependencies; used by mcra_noise_estimator.
package mcra_pkg;

    // Field widths of the requests.
    localparam int MAG_W   = 16;
    localparam int BIN_W   = 7;
    localparam int PROB_W  = 9;
    localparam int RATIO_W = 4;

    // Default number of frequency bins.
    localparam int NUM_BINS_DEF = 128;

    // Reset value of the presence ratio register.
    localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd3;

    // Smoothing weights in units of 1/256.
    localparam logic [7:0] MAG_KEEP   = 8'd205;  // 0.8
    localparam logic [7:0] MAG_NEW    = 8'd51;   // 0.2
    localparam logic [7:0] PROB_KEEP  = 8'd102;  // 0.4
    localparam logic [7:0] PROB_NEW   = 8'd154;  // 0.6
    localparam logic [7:0] NOISE_KEEP = 8'd230;  // 0.9
    localparam logic [7:0] NOISE_NEW  = 8'd26;   // 0.1

    // Rounding offset for a shift right by eight.
    localparam logic [7:0] ROUND_HALF = 8'd128;

    // Input request.
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [BIN_W-1:0] bin_index;
        logic             first_frame;
    } t_mcra_in;

    // Result request.
    typedef struct packed {
        logic [MAG_W-1:0]  noise_estimate;
        logic              speech_flag;
        logic [PROB_W-1:0] presence_prob;
    } t_mcra_out;

    // Per-bin state word kept in the state memory.
    typedef struct packed {
        logic [MAG_W-1:0]  smoothed_mag;
        logic [MAG_W-1:0]  temp_min_mag;
        logic [PROB_W-1:0] speech_prob;
        logic [MAG_W-1:0]  noise_mag;
    } t_mcra_state;

    localparam int STATE_W = $bits(t_mcra_state);

endpackage

@@ src/mcra_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and updates only on a read enable.
// No dependencies.
module mcra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; old data is returned on a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mcra_noise_estimator.sv @@
// Top level of the minima-controlled recursive-averaging noise estimator.
// Depends on mcra_pkg for types and weights and on mcra_ram for the state memory.
//
//   channel   direction  handshake                    payload
//   config    in         i_cfg_we                     i_cfg_wdata (presence ratio)
//   input     in         i_in_valid / o_in_ready      i_in  (mcra_pkg::t_mcra_in)
//   result    out        o_out_valid / i_out_ready    o_out (mcra_pkg::t_mcra_out)
//
// One item per cycle is accepted while no item in flight names the same bin and the result is not stalled.
// A result passes these steps after acceptance: memory read at the accepting edge,
// then magnitude smoothing, presence update, noise update into the output register.
// An item whose bin is still held by one of the three stages before write-back
// waits until that write to the state memory is done.
// Reset is synchronous; it clears only the pipeline valids and loads the ratio register with RATIO_RESET;
// the state memory holds nothing defined until a first-frame request for a bin.
module mcra_noise_estimator #(
    parameter int NUM_BINS = mcra_pkg::NUM_BINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcra_pkg::RATIO_W-1:0]      i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mcra_pkg::t_mcra_in                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mcra_pkg::t_mcra_out               o_out
);

    localparam int AW        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int BIN_CODES = 2 ** mcra_pkg::BIN_W;
    localparam int MW        = mcra_pkg::MAG_W;
    localparam int PW        = mcra_pkg::PROB_W;
    localparam int RW        = mcra_pkg::RATIO_W;
    localparam int ACC_W     = MW + 8;

    // Configuration register.
    logic [RW-1:0] r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= mcra_pkg::RATIO_RESET;
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_wdata;
        end
    end

    // Bin index folded onto the memory depth by a constant table.
    logic [AW-1:0] w_bin_map [BIN_CODES];

    for (genvar g = 0; g < BIN_CODES; g++) begin : g_bin_map
        assign w_bin_map[g] = AW'(g % NUM_BINS);
    end

    logic [AW-1:0] w_in_addr;
    assign w_in_addr = w_bin_map[i_in.bin_index];

    // Pipeline registers.
    logic                     r_v1, r_v2, r_v3, r_out_valid;
    logic [AW-1:0]            r_a1, r_a2, r_a3;
    logic [MW-1:0]            r_mag1;
    logic                     r_first1;
    logic [MW-1:0]            r_s2, r_tm2, r_mn2, r_t2, r_n2;
    logic [14:0]              r_pk2;
    logic [MW-1:0]            r_s3, r_tm3, r_t3;
    logic signed [MW:0]       r_d3;
    logic [PW-1:0]            r_p3;
    logic                     r_flag3;
    mcra_pkg::t_mcra_out      r_out;

    // Stage advance controls, from the output back to the input.
    logic w_adv1, w_adv2, w_adv3, w_hazard, w_accept;

    assign w_adv3   = !r_out_valid || i_out_ready;
    assign w_adv2   = !r_v3 || w_adv3;
    assign w_adv1   = !r_v2 || w_adv2;

    // Same-bin interlock: wait until every older request for this bin is written back.
    assign w_hazard = (r_v1 && (r_a1 == w_in_addr)) ||
                      (r_v2 && (r_a2 == w_in_addr)) ||
                      (r_v3 && (r_a3 == w_in_addr));

    assign o_in_ready = (!r_v1 || w_adv1) && !w_hazard;
    assign w_accept   = i_in_valid && o_in_ready;

    // State memory.
    mcra_pkg::t_mcra_state w_rd_state, w_wr_state;
    logic [mcra_pkg::STATE_W-1:0] w_rdata;
    logic w_ram_we;

    assign w_ram_we   = r_v3 && w_adv3;
    assign w_rd_state = mcra_pkg::t_mcra_state'(w_rdata);

    mcra_ram #(
        .WIDTH (mcra_pkg::STATE_W),
        .DEPTH (NUM_BINS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_a3),
        .i_wdata (w_wr_state),
        .i_re    (w_accept),
        .i_raddr (w_in_addr),
        .o_rdata (w_rdata)
    );

    // Stage 1: pick the old state, smooth the magnitude, track minima, start both recursions.
    mcra_pkg::t_mcra_state w_old;
    logic [ACC_W-1:0] n_s_acc, n_t_acc;
    logic [MW-1:0]    n_s, n_tm, n_mn, n_t;
    logic [14:0]      n_pk;

    always_comb begin
        if (r_first1) begin
            w_old.smoothed_mag = r_mag1;
            w_old.temp_min_mag = r_mag1;
            w_old.speech_prob  = '0;
            w_old.noise_mag    = r_mag1;
        end else begin
            w_old = w_rd_state;
        end
        n_s_acc = ACC_W'(w_old.smoothed_mag) * ACC_W'(mcra_pkg::MAG_KEEP)
                + ACC_W'(r_mag1) * ACC_W'(mcra_pkg::MAG_NEW)
                + ACC_W'(mcra_pkg::ROUND_HALF);
        n_s     = n_s_acc[ACC_W-1:8];
        n_t_acc = ACC_W'(w_old.noise_mag) * ACC_W'(mcra_pkg::NOISE_KEEP)
                + ACC_W'(r_mag1) * ACC_W'(mcra_pkg::NOISE_NEW)
                + ACC_W'(mcra_pkg::ROUND_HALF);
        n_t     = n_t_acc[ACC_W-1:8];
        // The window restarts every frame; the minimum also takes old and new smoothed values.
        n_mn    = (w_old.temp_min_mag < w_old.smoothed_mag) ? w_old.temp_min_mag
                                                            : w_old.smoothed_mag;
        if (n_s < n_mn) begin
            n_mn = n_s;
        end
        n_tm    = (n_s < w_old.smoothed_mag) ? n_s : w_old.smoothed_mag;
        n_pk    = 15'(w_old.speech_prob) * 15'(mcra_pkg::PROB_KEEP);
    end

    // Stage 2: speech decision and presence probability smoothing.
    logic [MW+RW-1:0] n_lim;
    logic             n_flag;
    logic [16:0]      n_p_acc;
    logic [PW-1:0]    n_p;
    logic signed [MW:0] n_d;

    always_comb begin
        n_lim   = (MW+RW)'(r_mn2) * (MW+RW)'(r_ratio);
        n_flag  = (MW+RW)'(r_s2) > n_lim;
        n_p_acc = 17'(r_pk2) + 17'(mcra_pkg::ROUND_HALF)
                + (n_flag ? 17'({mcra_pkg::PROB_NEW, 8'd0}) : 17'd0);
        n_p     = n_p_acc[16:8];
        n_d     = $signed({1'b0, r_n2}) - $signed({1'b0, r_t2});
    end

    // Stage 3: probability-gated noise update, N' = T + P' * (N - T) / 256 rounded.
    logic signed [MW+PW+1:0] n_prod;
    logic signed [MW+PW+1:0] n_prod_r;
    logic signed [MW+3:0]    n_n_sum;
    logic [MW-1:0]           n_noise;

    always_comb begin
        n_prod   = (MW+PW+2)'($signed({1'b0, r_p3})) * (MW+PW+2)'(r_d3);
        n_prod_r = n_prod + (MW+PW+2)'(mcra_pkg::ROUND_HALF);
        n_n_sum  = $signed({4'b0, r_t3}) + (MW+4)'($signed(n_prod_r[MW+PW+1:8]));
        n_noise  = n_n_sum[MW-1:0];
    end

    // Write-back word for the state memory.
    always_comb begin
        w_wr_state.smoothed_mag = r_s3;
        w_wr_state.temp_min_mag = r_tm3;
        w_wr_state.speech_prob  = r_p3;
        w_wr_state.noise_mag    = n_noise;
    end

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_v1 || w_adv1) begin
                r_v1 <= w_accept;
            end
            if (w_adv1) begin
                r_v2 <= r_v1;
            end
            if (w_adv2) begin
                r_v3 <= r_v2;
            end
            if (w_adv3) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a1     <= w_in_addr;
            r_mag1   <= i_in.magnitude;
            r_first1 <= i_in.first_frame;
        end
        if (w_adv1 && r_v1) begin
            r_a2  <= r_a1;
            r_s2  <= n_s;
            r_tm2 <= n_tm;
            r_mn2 <= n_mn;
            r_t2  <= n_t;
            r_n2  <= w_old.noise_mag;
            r_pk2 <= n_pk;
        end
        if (w_adv2 && r_v2) begin
            r_a3    <= r_a2;
            r_s3    <= r_s2;
            r_tm3   <= r_tm2;
            r_t3    <= r_t2;
            r_d3    <= n_d;
            r_p3    <= n_p;
            r_flag3 <= n_flag;
        end
        if (w_adv3 && r_v3) begin
            r_out.noise_estimate <= n_noise;
            r_out.speech_flag    <= r_flag3;
            r_out.presence_prob  <= r_p3;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // The interlock keeps a read from meeting the write-back of the same bin.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && w_accept) |-> (r_a3 != w_in_addr))
        else $error("state memory read and write hit the same bin in one cycle");

    // The smoothed presence probability never exceeds one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.presence_prob <= 9'd256))
        else $error("presence probability above one");

    // An accepted request occupies the first stage in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted request lost at the memory read stage");

    // A stalled result stage keeps its request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_adv3) |=> r_v3)
        else $error("noise update stage dropped a stalled request");
`endif

endmodule
